[rtl/hkm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hkm_pkg
// Shared types and constants of the hunt-and-kill maze step engine.
// ----------------------------------------------------------------------------
package hkm_pkg;

  localparam int MAX_SIDE = 32;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int SIZE_W   = 6;
  localparam int ROW_W    = MAX_SIDE;
  localparam int RAND_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KILL,
    ST_HUNT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              req_type;
    logic [RAND_W-1:0] rand_value;
  } req_t;

  typedef struct packed {
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [1:0] wall_dir;
    logic       carved;
    logic       hunting;
    logic       finished;
  } resp_t;

endpackage

`default_nettype wire

[rtl/hunt_and_kill_maze_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hunt_and_kill_maze_step
// Hunt-and-kill maze generator, one step per transaction, visited map in a
// row-wide synchronous memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows, shown for one cycle with out_valid, and it must be taken
// then. A clear request answers in the cycle after acceptance. A kill step
// reads the three rows around the walking cell through the single memory
// read port, then answers. A hunt step streams the rows of the grid through
// the same port, one row per cycle, and answers once it finds a cell or
// when nothing is left. After reset the map is ready at once: each row has
// a valid bit, and a clear request resets those bits.
module hunt_and_kill_maze_step (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire hkm_pkg::req_t                  in_data,
  output logic                                out_valid,
  output hkm_pkg::resp_t                      out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hkm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hkm_pkg::SIZE_W-1:0]     cfg_data
);

  localparam int CW = hkm_pkg::COORD_W;
  localparam int SW = hkm_pkg::SIZE_W;
  localparam int RW = hkm_pkg::ROW_W;

  // configuration
  logic [SW-1:0] grid_w_r;
  logic [SW-1:0] grid_h_r;
  logic [SW-1:0] w_eff;
  logic [SW-1:0] h_eff;
  logic [RW-1:0] wmask;

  // control state
  hkm_pkg::state_t  state_r, state_nxt;
  logic [SW-1:0]    c_r, c_nxt;
  logic [CW-1:0]    walk_x_r, walk_x_nxt;
  logic [CW-1:0]    walk_y_r, walk_y_nxt;
  logic             hunt_r, hunt_nxt;
  logic             done_r, done_nxt;
  logic [RW-1:0]    row_vld_r;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [hkm_pkg::RAND_W-1:0] rnd_r, rnd_nxt;
  logic [CW-1:0]    fx_r, fx_nxt;
  logic [CW-1:0]    fy_r, fy_nxt;
  logic [RW-1:0]    up_raw_r, up_raw_nxt;
  logic [RW-1:0]    mid_raw_r, mid_raw_nxt;
  logic [RW-1:0]    dn_raw_r, dn_raw_nxt;
  logic             up_ok_r, up_ok_nxt;
  logic             mid_ok_r, mid_ok_nxt;
  hkm_pkg::resp_t   out_resp_r, out_resp_nxt;

  // memory
  logic [RW-1:0]    mem [hkm_pkg::MAX_SIDE];
  logic [RW-1:0]    mem_q_r;
  logic             vld_q_r;
  logic [CW-1:0]    rq_addr_r;
  logic [SW-1:0]    rq_idx_r;
  logic             mem_re;
  logic [CW-1:0]    mem_raddr;
  logic [SW-1:0]    rd_idx;
  logic             mem_we;
  logic [CW-1:0]    mem_waddr;
  logic [RW-1:0]    mem_wdata;
  logic             row_clear;

  // row window and hunt search
  logic [RW-1:0]    cur_raw;
  logic             cur_ok;
  logic [RW-1:0]    upm, midm, curm;
  logic [RW-1:0]    hcand;
  logic             hfound;
  logic [CW-1:0]    hx;
  logic [SW-1:0]    kidx;
  logic [SW-1:0]    e_idx;

  // neighbour pick
  logic [3:0]       vis4, ex4, cand4;
  logic             in_grid;
  logic [2:0]       ncand;
  logic [1:0]       kpick;
  logic [1:0]       cnt;
  logic             got;
  hkm_pkg::dir_t    dsel;
  logic [CW-1:0]    nx, ny;

  function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = v;
    if (v == '0) r = SW'(1);
    else if (v > SW'(hkm_pkg::MAX_SIDE)) r = SW'(hkm_pkg::MAX_SIDE);
    return r;
  endfunction

  function automatic logic [1:0] mod3(input logic [hkm_pkg::RAND_W-1:0] v);
    logic [32:0] p;
    logic [15:0] q;
    logic [17:0] t;
    p = {17'b0, v} * 33'd43691;
    q = p[32:17];
    t = {2'b0, v} - ({2'b0, q} + {1'b0, q, 1'b0});
    return t[1:0];
  endfunction

  assign w_eff     = eff_size(grid_w_r);
  assign h_eff     = eff_size(grid_h_r);
  assign cfg_ready = 1'b1;
  assign busy      = (state_r != hkm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_resp_r;

  always_comb begin
    for (int i = 0; i < RW; i++) begin
      wmask[i] = (SW'(i) < w_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= SW'(hkm_pkg::MAX_SIDE);
      grid_h_r <= SW'(hkm_pkg::MAX_SIDE);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hkm_pkg::CFG_GRID_WIDTH:  grid_w_r <= cfg_data;
        hkm_pkg::CFG_GRID_HEIGHT: grid_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // read data with unwritten rows shown at their reset value
  assign cur_raw = vld_q_r ? mem_q_r : ((rq_addr_r == '0) ? RW'(1) : '0);
  assign cur_ok  = (rq_idx_r < h_eff);
  assign kidx    = {1'b0, walk_y_r} + c_r - SW'(1);
  assign e_idx   = c_r - SW'(2);

  always_comb begin
    upm    = up_ok_r  ? (up_raw_r  & wmask) : '0;
    midm   = mid_ok_r ? (mid_raw_r & wmask) : '0;
    curm   = cur_ok   ? (cur_raw   & wmask) : '0;
    hcand  = ~midm & wmask & (upm | curm | (midm << 1) | (midm >> 1));
    hfound = (hcand != '0);
    hx     = '0;
    for (int i = RW - 1; i >= 0; i--) begin
      if (hcand[i]) hx = CW'(i);
    end
  end

  always_comb begin
    in_grid = hunt_r || (({1'b0, fx_r} < w_eff) && ({1'b0, fy_r} < h_eff));
    ex4[hkm_pkg::DIR_N] = (fy_r != '0);
    ex4[hkm_pkg::DIR_E] = (({1'b0, fx_r} + SW'(1)) < w_eff);
    ex4[hkm_pkg::DIR_S] = (({1'b0, fy_r} + SW'(1)) < h_eff);
    ex4[hkm_pkg::DIR_W] = (fx_r != '0);
    vis4[hkm_pkg::DIR_N] = up_raw_r[fx_r];
    vis4[hkm_pkg::DIR_E] = mid_raw_r[fx_r + CW'(1)];
    vis4[hkm_pkg::DIR_S] = dn_raw_r[fx_r];
    vis4[hkm_pkg::DIR_W] = mid_raw_r[fx_r - CW'(1)];
    cand4 = (in_grid ? ex4 : 4'b0) & (hunt_r ? vis4 : ~vis4);
    ncand = 3'($countones(cand4));
    case (ncand)
      3'd2:    kpick = {1'b0, rnd_r[0]};
      3'd3:    kpick = mod3(rnd_r);
      3'd4:    kpick = rnd_r[1:0];
      default: kpick = 2'd0;
    endcase
    cnt  = 2'd0;
    got  = 1'b0;
    dsel = hkm_pkg::DIR_N;
    for (int d = 0; d < 4; d++) begin
      if (cand4[d] && !got) begin
        if (cnt == kpick) begin
          dsel = hkm_pkg::dir_t'(d);
          got  = 1'b1;
        end
        cnt = cnt + 2'd1;
      end
    end
    nx = fx_r;
    ny = fy_r;
    case (dsel)
      hkm_pkg::DIR_N: ny = fy_r - CW'(1);
      hkm_pkg::DIR_E: nx = fx_r + CW'(1);
      hkm_pkg::DIR_S: ny = fy_r + CW'(1);
      hkm_pkg::DIR_W: nx = fx_r - CW'(1);
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    c_nxt         = c_r;
    walk_x_nxt    = walk_x_r;
    walk_y_nxt    = walk_y_r;
    hunt_nxt      = hunt_r;
    done_nxt      = done_r;
    out_valid_nxt = 1'b0;
    rnd_nxt       = rnd_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    up_raw_nxt    = up_raw_r;
    mid_raw_nxt   = mid_raw_r;
    dn_raw_nxt    = dn_raw_r;
    up_ok_nxt     = up_ok_r;
    mid_ok_nxt    = mid_ok_r;
    out_resp_nxt  = out_resp_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    rd_idx        = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    row_clear     = 1'b0;
    case (state_r)
      hkm_pkg::ST_IDLE: begin
        if (start) begin
          rnd_nxt = in_data.rand_value;
          c_nxt   = '0;
          if (in_data.req_type == hkm_pkg::REQ_CLEAR) begin
            row_clear     = 1'b1;
            walk_x_nxt    = '0;
            walk_y_nxt    = '0;
            hunt_nxt      = 1'b0;
            done_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
            out_resp_nxt  = '0;
          end else if (done_r) begin
            out_valid_nxt         = 1'b1;
            out_resp_nxt          = '0;
            out_resp_nxt.hunting  = hunt_r;
            out_resp_nxt.finished = 1'b1;
          end else if (!hunt_r) begin
            fx_nxt    = walk_x_r;
            fy_nxt    = walk_y_r;
            state_nxt = hkm_pkg::ST_KILL;
          end else begin
            up_raw_nxt  = '0;
            mid_raw_nxt = '0;
            up_ok_nxt   = 1'b0;
            mid_ok_nxt  = 1'b0;
            state_nxt   = hkm_pkg::ST_HUNT;
          end
        end
      end
      hkm_pkg::ST_KILL: begin
        if (c_r < SW'(3)) begin
          mem_re    = 1'b1;
          mem_raddr = kidx[CW-1:0];
          rd_idx    = kidx;
        end
        if (c_r == SW'(3)) begin
          dn_raw_nxt = cur_raw;
          state_nxt  = hkm_pkg::ST_FIN;
        end else if (c_r != '0) begin
          up_raw_nxt  = mid_raw_r;
          mid_raw_nxt = cur_raw;
        end
        c_nxt = c_r + SW'(1);
      end
      hkm_pkg::ST_HUNT: begin
        mem_re    = 1'b1;
        mem_raddr = c_r[CW-1:0];
        rd_idx    = c_r;
        if ((c_r >= SW'(2)) && hfound) begin
          mem_re     = 1'b0;
          fx_nxt     = hx;
          fy_nxt     = e_idx[CW-1:0];
          dn_raw_nxt = cur_raw;
          state_nxt  = hkm_pkg::ST_FIN;
        end else if (c_r == h_eff + SW'(1)) begin
          mem_re                = 1'b0;
          done_nxt              = 1'b1;
          out_valid_nxt         = 1'b1;
          out_resp_nxt          = '0;
          out_resp_nxt.hunting  = 1'b1;
          out_resp_nxt.finished = 1'b1;
          state_nxt             = hkm_pkg::ST_IDLE;
        end else begin
          if (c_r != '0) begin
            up_raw_nxt  = mid_raw_r;
            up_ok_nxt   = mid_ok_r;
            mid_raw_nxt = cur_raw;
            mid_ok_nxt  = cur_ok;
          end
          c_nxt = c_r + SW'(1);
        end
      end
      hkm_pkg::ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_resp_nxt  = '0;
        state_nxt     = hkm_pkg::ST_IDLE;
        if (!hunt_r) begin
          if (cand4 == 4'b0) begin
            hunt_nxt             = 1'b1;
            out_resp_nxt.hunting = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = ny;
            case (dsel)
              hkm_pkg::DIR_N: mem_wdata = up_raw_r;
              hkm_pkg::DIR_S: mem_wdata = dn_raw_r;
              default:        mem_wdata = mid_raw_r;
            endcase
            mem_wdata             = mem_wdata | (RW'(1) << nx);
            walk_x_nxt            = nx;
            walk_y_nxt            = ny;
            out_resp_nxt.cell_x   = fx_r;
            out_resp_nxt.cell_y   = fy_r;
            out_resp_nxt.wall_dir = dsel;
            out_resp_nxt.carved   = 1'b1;
          end
        end else begin
          mem_we                = 1'b1;
          mem_waddr             = fy_r;
          mem_wdata             = mid_raw_r | (RW'(1) << fx_r);
          walk_x_nxt            = fx_r;
          walk_y_nxt            = fy_r;
          hunt_nxt              = 1'b0;
          out_resp_nxt.cell_x   = nx;
          out_resp_nxt.cell_y   = ny;
          out_resp_nxt.wall_dir = dsel ^ 2'd2;
          out_resp_nxt.carved   = 1'b1;
        end
      end
      default: state_nxt = hkm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hkm_pkg::ST_IDLE;
      c_r         <= '0;
      walk_x_r    <= '0;
      walk_y_r    <= '0;
      hunt_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      c_r         <= c_nxt;
      walk_x_r    <= walk_x_nxt;
      walk_y_r    <= walk_y_nxt;
      hunt_r      <= hunt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r      <= rnd_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    up_raw_r   <= up_raw_nxt;
    mid_raw_r  <= mid_raw_nxt;
    dn_raw_r   <= dn_raw_nxt;
    up_ok_r    <= up_ok_nxt;
    mid_ok_r   <= mid_ok_nxt;
    out_resp_r <= out_resp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || row_clear) begin
      row_vld_r <= '0;
    end else if (mem_we) begin
      row_vld_r[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r   <= mem[mem_raddr];
      vld_q_r   <= row_vld_r[mem_raddr];
      rq_addr_r <= mem_raddr;
      rq_idx_r  <= rd_idx;
    end
  end

endmodule

`default_nettype wire

[rtl/hkm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hkm_checker
// Port-level checks of the maze step engine, bound to the top level.
// ----------------------------------------------------------------------------
module hkm_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire hkm_pkg::req_t                  in_data,
  input wire logic                           out_valid,
  input wire hkm_pkg::resp_t                 out_data
);

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_clear_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.req_type == hkm_pkg::REQ_CLEAR)
      |=> (out_valid && out_data == '0))
    else $error("clear transaction not answered with zero result");

  a_no_carve_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.carved)
      |-> (out_data.cell_x == '0 && out_data.cell_y == '0 && out_data.wall_dir == '0))
    else $error("uncarved result carries a location");

  a_done_in_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.finished) |-> (out_data.hunting && !out_data.carved))
    else $error("finished result outside hunt phase or with a carve");

endmodule

bind hunt_and_kill_maze_step hkm_checker u_hkm_checker (.*);

`default_nettype wire

[tb/hunt_and_kill_maze_step_test.sv]
// ----------------------------------------------------------------------------
// hunt_and_kill_maze_step_test
// Self-checking bench for the hunt-and-kill maze step engine. A behavioral
// maze model predicts every result. Directed tests cover the reset grid, a
// single cell, clamped sizes, a grid that shrinks under the walker and the
// unused register indexes. Random mazes of many shapes then run until the
// maze is complete or a step budget is spent, with stray clears and size
// changes, and random gaps on the request and register channels.
// ----------------------------------------------------------------------------
module hunt_and_kill_maze_step_test;

  localparam logic [hkm_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [hkm_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int RANDOM_ITEMS = 1750;
  localparam int TAIL_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT = 800000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  hkm_pkg::req_t                 in_data = '0;
  logic                          out_valid;
  hkm_pkg::resp_t                out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [hkm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hkm_pkg::SIZE_W-1:0]    cfg_data = '0;

  logic [hkm_pkg::ROW_W-1:0]  vis_map [hkm_pkg::MAX_SIDE];
  int                         walk_col;
  int                         walk_row;
  bit                         in_hunt;
  bit                         all_done;
  logic [hkm_pkg::SIZE_W-1:0] cols_reg;
  logic [hkm_pkg::SIZE_W-1:0] rows_reg;

  hkm_pkg::resp_t carve_due [$];
  hkm_pkg::resp_t due_head;
  int    fails = 0;
  int    sent_cnt = 0;
  int    checked_cnt = 0;
  int    carve_cnt = 0;
  int    done_cnt = 0;
  bit    steady = 1'b0;
  int unsigned cycles = 0;

  hunt_and_kill_maze_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int clamp_side(logic [hkm_pkg::SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > hkm_pkg::MAX_SIDE) return hkm_pkg::MAX_SIDE;
    return int'(v);
  endfunction

  function automatic bit step_to(int x, int y, hkm_pkg::dir_t d, int w, int h,
                                 output int nx, output int ny);
    nx = x;
    ny = y;
    case (d)
      hkm_pkg::DIR_N: ny = y - 1;
      hkm_pkg::DIR_E: nx = x + 1;
      hkm_pkg::DIR_S: ny = y + 1;
      hkm_pkg::DIR_W: nx = x - 1;
      default: ;
    endcase
    return nx >= 0 && ny >= 0 && nx < w && ny < h;
  endfunction

  function automatic int pick_dirs(int x, int y, int w, int h, bit want,
                                   output hkm_pkg::dir_t dirs[4]);
    int            n;
    int            nx;
    int            ny;
    hkm_pkg::dir_t d;
    n = 0;
    for (int i = 0; i < 4; i++) dirs[i] = hkm_pkg::DIR_N;
    if (x < 0 || y < 0 || x >= w || y >= h) return 0;
    for (int i = 0; i < 4; i++) begin
      d = hkm_pkg::dir_t'(i);
      if (step_to(x, y, d, w, h, nx, ny) && (vis_map[ny][nx] == want)) begin
        dirs[n] = d;
        n++;
      end
    end
    return n;
  endfunction

  function automatic void wipe_maze();
    foreach (vis_map[i]) vis_map[i] = '0;
    vis_map[0][0] = 1'b1;
    walk_col = 0;
    walk_row = 0;
    in_hunt  = 1'b0;
    all_done = 1'b0;
  endfunction

  function automatic hkm_pkg::resp_t carve_step(hkm_pkg::req_t rq);
    hkm_pkg::resp_t r;
    int             w;
    int             h;
    int             n;
    int             nx;
    int             ny;
    int             sel;
    int             rx;
    int             ry;
    bit             found;
    hkm_pkg::dir_t  dirs[4];
    w = clamp_side(cols_reg);
    h = clamp_side(rows_reg);
    r = '0;
    if (rq.req_type == hkm_pkg::REQ_CLEAR) begin
      wipe_maze();
    end else if (!all_done) begin
      if (!in_hunt) begin
        n = pick_dirs(walk_col, walk_row, w, h, 1'b0, dirs);
        if (n == 0) begin
          in_hunt = 1'b1;
        end else begin
          sel = int'(rq.rand_value) % n;
          void'(step_to(walk_col, walk_row, dirs[sel], w, h, nx, ny));
          vis_map[ny][nx] = 1'b1;
          r.cell_x   = 5'(walk_col);
          r.cell_y   = 5'(walk_row);
          r.wall_dir = dirs[sel];
          r.carved   = 1'b1;
          walk_col   = nx;
          walk_row   = ny;
        end
      end else begin
        found = 1'b0;
        n = 0;
        for (ry = 0; ry < h && !found; ry++) begin
          for (rx = 0; rx < w && !found; rx++) begin
            if (!vis_map[ry][rx]) begin
              n = pick_dirs(rx, ry, w, h, 1'b1, dirs);
              if (n > 0) begin
                found    = 1'b1;
                walk_col = rx;
                walk_row = ry;
              end
            end
          end
        end
        if (!found) begin
          all_done = 1'b1;
        end else begin
          sel = int'(rq.rand_value) % n;
          void'(step_to(walk_col, walk_row, dirs[sel], w, h, nx, ny));
          vis_map[walk_row][walk_col] = 1'b1;
          r.cell_x   = 5'(nx);
          r.cell_y   = 5'(ny);
          r.wall_dir = hkm_pkg::dir_t'((int'(dirs[sel]) + 2) % 4);
          r.carved   = 1'b1;
          in_hunt    = 1'b0;
        end
      end
    end
    r.hunting  = in_hunt;
    r.finished = all_done;
    return r;
  endfunction

  function automatic logic [hkm_pkg::RAND_W-1:0] rand16();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return hkm_pkg::RAND_W'($urandom_range(0, 65535));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (carve_due.size() == 0) begin
        $error("result transaction with nothing expected");
        fails++;
      end else begin
        due_head = carve_due.pop_front();
        checked_cnt++;
        if (out_data.carved) carve_cnt++;
        if (out_data.finished) done_cnt++;
        if (out_data.cell_x !== due_head.cell_x) begin
          $error("cell_x: expected %0d, actual %0d", due_head.cell_x, out_data.cell_x);
          fails++;
        end
        if (out_data.cell_y !== due_head.cell_y) begin
          $error("cell_y: expected %0d, actual %0d", due_head.cell_y, out_data.cell_y);
          fails++;
        end
        if (out_data.wall_dir !== due_head.wall_dir) begin
          $error("wall_dir: expected %0d, actual %0d", due_head.wall_dir,
                 out_data.wall_dir);
          fails++;
        end
        if (out_data.carved !== due_head.carved) begin
          $error("carved: expected %0d, actual %0d", due_head.carved, out_data.carved);
          fails++;
        end
        if (out_data.hunting !== due_head.hunting) begin
          $error("hunting: expected %0d, actual %0d", due_head.hunting,
                 out_data.hunting);
          fails++;
        end
        if (out_data.finished !== due_head.finished) begin
          $error("finished: expected %0d, actual %0d", due_head.finished,
                 out_data.finished);
          fails++;
        end
      end
    end
  end

  task automatic send_req(input logic kind, input logic [hkm_pkg::RAND_W-1:0] rnd);
    int            gap;
    hkm_pkg::req_t rq;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rq.req_type   = kind;
    rq.rand_value = rnd;
    start   <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    carve_due.insert(carve_due.size(), carve_step(rq));
    sent_cnt++;
  endtask

  task automatic walk_step();
    send_req(hkm_pkg::REQ_STEP, rand16());
  endtask

  task automatic restart_maze();
    send_req(hkm_pkg::REQ_CLEAR, rand16());
  endtask

  // hold off until the engine is idle and every expected result has arrived
  task automatic settle();
    start <= 1'b0;
    while (carve_due.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hkm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hkm_pkg::SIZE_W-1:0] val);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == hkm_pkg::CFG_GRID_WIDTH) cols_reg = val;
    else if (idx == hkm_pkg::CFG_GRID_HEIGHT) rows_reg = val;
  endtask

  task automatic set_grid(input logic [hkm_pkg::SIZE_W-1:0] w,
                          input logic [hkm_pkg::SIZE_W-1:0] h);
    settle();
    write_reg(hkm_pkg::CFG_GRID_WIDTH, w);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                hkm_pkg::SIZE_W'($urandom));
    write_reg(hkm_pkg::CFG_GRID_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_grid();
    send_req(hkm_pkg::REQ_STEP, '0);
    send_req(hkm_pkg::REQ_STEP, '1);
    restart_maze();
  endtask

  task automatic test_single_cell();
    set_grid(6'd1, 6'd1);
    restart_maze();
    repeat (3) walk_step();
  endtask

  task automatic test_size_clamp();
    set_grid(6'd0, 6'd63);
    restart_maze();
    repeat (4) walk_step();
    set_grid(6'd63, 6'd0);
    restart_maze();
    repeat (3) walk_step();
  endtask

  task automatic test_shrink_under_walker();
    set_grid(6'd8, 6'd8);
    restart_maze();
    repeat (4) walk_step();
    set_grid(6'd2, 6'd2);
    repeat (3) walk_step();
  endtask

  task automatic test_spare_index();
    settle();
    write_reg(CFG_SPARE_LO, 6'd1);
    write_reg(CFG_SPARE_HI, 6'd1);
    cfg_valid <= 1'b0;
    repeat (2) walk_step();
  endtask

  task automatic test_random_mazes();
    int made;
    int phase;
    int steps;
    int room;
    int pick;
    int roll;
    logic [hkm_pkg::SIZE_W-1:0] w;
    logic [hkm_pkg::SIZE_W-1:0] h;
    made  = 0;
    phase = 0;
    while (made < RANDOM_ITEMS) begin
      steady = (made >= 700 && made < 1000);
      pick = (phase == 0) ? 70 : (phase == 1) ? 75 : (phase == 2) ? 90 :
             $urandom_range(0, 99);
      room = 600;
      if (pick < 55) begin
        w = hkm_pkg::SIZE_W'($urandom_range(1, 6));
        h = hkm_pkg::SIZE_W'($urandom_range(1, 6));
      end else if (pick < 70) begin
        w = hkm_pkg::SIZE_W'($urandom_range(7, 12));
        h = hkm_pkg::SIZE_W'($urandom_range(7, 12));
      end else if (pick < 80) begin
        if (pick < 75) begin
          w = 6'd32;
          h = hkm_pkg::SIZE_W'($urandom_range(1, 2));
        end else begin
          w = hkm_pkg::SIZE_W'($urandom_range(1, 2));
          h = 6'd32;
        end
      end else if (pick < 88) begin
        w = $urandom_range(0, 1) ? 6'd0 : hkm_pkg::SIZE_W'($urandom_range(33, 63));
        h = hkm_pkg::SIZE_W'($urandom_range(1, 6));
        if ($urandom_range(0, 1)) {w, h} = {h, w};
      end else if (pick < 92) begin
        w = 6'd32;
        h = 6'd32;
        room = 250;
      end else begin
        w = hkm_pkg::SIZE_W'($urandom_range(13, 16));
        h = hkm_pkg::SIZE_W'($urandom_range(13, 16));
      end
      set_grid(w, h);
      restart_maze();
      made++;
      steps = 0;
      while (!all_done && steps < room && made < RANDOM_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          restart_maze();
        end else if (roll < 3) begin
          set_grid(hkm_pkg::SIZE_W'($urandom_range(1, 8)),
                   hkm_pkg::SIZE_W'($urandom_range(1, 8)));
          walk_step();
        end else begin
          walk_step();
        end
        steps++;
        made++;
      end
      repeat ($urandom_range(0, 3)) begin
        walk_step();
        made++;
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    wipe_maze();
    cols_reg = 6'd32;
    rows_reg = 6'd32;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_grid();
    test_single_cell();
    test_size_clamp();
    test_shrink_under_walker();
    test_spare_index();
    test_random_mazes();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (carve_due.size() != 0) begin
      $error("%0d expected results never arrived", carve_due.size());
      fails++;
    end
    $display("Sent %0d step/clear transactions, checked %0d results.", sent_cnt,
             checked_cnt);
    $display("Results with a carve: %0d, results with the maze complete: %0d.",
             carve_cnt, done_cnt);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hkm_pkg.sv
rtl/hunt_and_kill_maze_step.sv
rtl/hkm_checker.sv
tb/hunt_and_kill_maze_step_test.sv
